// ----- design/gcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// gcpf_pkg
// Shared types and constants of the grid cell persistence filter: field
// widths, the per-cell store entry and the reset threshold.
// ----------------------------------------------------------------------------
package gcpf_pkg;

  localparam int unsigned COORD_W          = 7;
  localparam int unsigned CNT_W            = 4;
  localparam int unsigned GRID_SIDE_DEFAULT = 128;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam cnt_t THRESH_RESET = cnt_t'(10);
  localparam cnt_t CNT_MAX      = '1;

  // One word of the per-cell store: previous observed bit and hit counter.
  typedef struct packed {
    logic prev_seen;
    cnt_t hit_counter;
  } entry_t;

  // Outcome of one counter update.
  typedef struct packed {
    entry_t entry;
    logic   newly_confirmed;
    logic   confirmed;
  } upd_res_t;

endpackage

// ----- design/gcpf_ifs.sv -----
// ----------------------------------------------------------------------------
// gcpf channel interfaces
// Valid/ready channels for cell observations, filter results and the
// threshold configuration write.
// ----------------------------------------------------------------------------
interface gcpf_cell_if;
  logic             valid;
  logic             ready;
  gcpf_pkg::coord_t cell_row;
  gcpf_pkg::coord_t cell_col;
  logic             occupied;

  modport source (output valid, cell_row, cell_col, occupied, input ready);
  modport sink   (input valid, cell_row, cell_col, occupied, output ready);
endinterface

interface gcpf_result_if;
  logic             valid;
  logic             ready;
  gcpf_pkg::coord_t out_row;
  gcpf_pkg::coord_t out_col;
  logic             newly_confirmed;
  logic             confirmed;

  modport source (output valid, out_row, out_col, newly_confirmed, confirmed,
                  input ready);
  modport sink   (input valid, out_row, out_col, newly_confirmed, confirmed,
                  output ready);
endinterface

interface gcpf_cfg_if;
  logic           valid;
  logic           ready;
  gcpf_pkg::cnt_t confirm_threshold;

  modport source (output valid, confirm_threshold, input ready);
  modport sink   (input valid, confirm_threshold, output ready);
endinterface

// ----- design/gcpf_cell_mem.sv -----
// ----------------------------------------------------------------------------
// gcpf_cell_mem
// Per-cell store: one synchronous memory, one write and one registered read
// port, with a zeroing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module gcpf_cell_mem #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output gcpf_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  gcpf_pkg::entry_t wr_data_i,
  output logic             clear_busy_o
);
  import gcpf_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  entry_t           mem [Depth];
  entry_t           rd_data_q;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             clr_busy_q, clr_busy_d;
  logic             we;
  logic [AddrW-1:0] waddr;
  entry_t           wdata;

  // Sweep one entry per cycle; drop busy after the last one.
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? entry_t'('0) : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clr_busy_q;

endmodule

// ----- design/gcpf_update.sv -----
// ----------------------------------------------------------------------------
// gcpf_update
// Counter update rule for one cell, driven by the previous observed bit.
// ----------------------------------------------------------------------------
module gcpf_update (
  input  gcpf_pkg::entry_t   entry_i,
  input  gcpf_pkg::cnt_t     thresh_i,
  input  logic               occupied_i,
  output gcpf_pkg::upd_res_t res_o
);
  import gcpf_pkg::*;

  cnt_t cnt;
  cnt_t cnt_next;
  logic newly;

  assign cnt = entry_i.hit_counter;

  always_comb begin
    cnt_next = cnt;
    newly    = 1'b0;
    if (entry_i.prev_seen) begin
      if (cnt < thresh_i) begin
        cnt_next = cnt + 1'b1;
      end else if (cnt == thresh_i) begin
        newly = 1'b1;
        // saturate rather than wrap at the top of the counter
        if (cnt != CNT_MAX) begin
          cnt_next = cnt + 1'b1;
        end
      end
    end else if (cnt < thresh_i) begin
      cnt_next = '0;
    end
  end

  assign res_o.entry.prev_seen   = occupied_i;
  assign res_o.entry.hit_counter = cnt_next;
  assign res_o.newly_confirmed   = newly;
  assign res_o.confirmed         = (cnt_next > thresh_i);

endmodule

// ----- design/grid_cell_persistence_filter.sv -----
// ----------------------------------------------------------------------------
// grid_cell_persistence_filter
// Per-cell persistence filter over a square occupancy grid. Keeps a hit
// counter and the previous occupied bit for every cell and reports when a
// cell becomes confirmed.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Transaction carries
//  --------  ---  ------------------------------------------------------
//  cell_i    in   cell_row, cell_col, occupied: one cell observation
//  res_o     out  out_row, out_col, newly_confirmed, confirmed
//  cfg_i     in   confirm_threshold (always ready)
//
//  Each observation is a read-modify-write: the accept edge issues the memory
//  read and enters S_UPDATE; the commit from S_UPDATE, once the result slot is
//  free, writes the updated entry back and loads the result register. With the
//  registered read and no overlap between successive read-modify-writes, a
//  new observation is not taken until the last one has committed. After reset
//  the cell memory is zeroed by a sweep over all GridSide*GridSide entries
//  (16384 at the default), during which cell_i is not ready.
//  A stalled result holds in the output register; a further observation is
//  still accepted and waits, with its read data held, until the slot frees.
// ----------------------------------------------------------------------------
module grid_cell_persistence_filter #(
  parameter int unsigned GridSide = gcpf_pkg::GRID_SIDE_DEFAULT
) (
  input logic          clk_i,
  input logic          rst_ni,
  gcpf_cell_if.sink    cell_i,
  gcpf_result_if.source res_o,
  gcpf_cfg_if.sink     cfg_i
);
  import gcpf_pkg::*;

  localparam int unsigned CellCount = GridSide * GridSide;
  localparam int unsigned AddrW     = (CellCount > 1) ? $clog2(CellCount) : 1;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

  state_e           state_q, state_d;
  cnt_t             thresh_q;

  // Observation held while its entry is read and updated.
  coord_t           row_q;
  coord_t           col_q;
  logic             occ_q;
  logic             in_grid_q;
  logic [AddrW-1:0] addr_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  coord_t           out_row_q;
  coord_t           out_col_q;
  logic             out_newly_q;
  logic             out_conf_q;

  logic             cell_acc;
  logic             in_grid;
  logic [AddrW-1:0] addr;
  logic             out_free;
  logic             commit;
  logic             clear_busy;
  entry_t           rd_entry;
  upd_res_t         upd;

  // Configuration: take every write, keep the low four bits.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_i.valid) begin
      thresh_q <= cfg_i.confirm_threshold;
    end
  end

  // Accept observations only while idle; the result slot is checked later.
  assign cell_i.ready = (state_q == S_IDLE);
  assign cell_acc     = cell_i.valid && cell_i.ready;

  // Cells outside the grid touch no state and report neither flag.
  assign in_grid = (32'(cell_i.cell_row) < GridSide) && (32'(cell_i.cell_col) < GridSide);
  assign addr    = AddrW'(32'(cell_i.cell_row) * GridSide + 32'(cell_i.cell_col));

  always_ff @(posedge clk_i) begin
    if (cell_acc) begin
      row_q     <= cell_i.cell_row;
      col_q     <= cell_i.cell_col;
      occ_q     <= cell_i.occupied;
      in_grid_q <= in_grid;
      addr_q    <= addr;
    end
  end

  gcpf_cell_mem #(
    .Depth (CellCount),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (cell_acc),
    .rd_addr_i    (addr),
    .rd_data_o    (rd_entry),
    .wr_en_i      (commit && in_grid_q),
    .wr_addr_i    (addr_q),
    .wr_data_i    (upd.entry),
    .clear_busy_o (clear_busy)
  );

  gcpf_update u_upd (
    .entry_i    (rd_entry),
    .thresh_i   (thresh_q),
    .occupied_i (occ_q),
    .res_o      (upd)
  );

  // Commit once the result slot is empty or being emptied this cycle.
  assign out_free = !out_valid_q || res_o.ready;
  assign commit   = (state_q == S_UPDATE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (!clear_busy) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cell_acc) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_row_q   <= row_q;
      out_col_q   <= col_q;
      out_newly_q <= in_grid_q && upd.newly_confirmed;
      out_conf_q  <= in_grid_q && upd.confirmed;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.out_row         = out_row_q;
  assign res_o.out_col         = out_col_q;
  assign res_o.newly_confirmed = out_newly_q;
  assign res_o.confirmed       = out_conf_q;

endmodule

// ----- dv/tb_grid_cell_persistence_filter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_cell_persistence_filter
// Self-checking bench for the grid cell persistence filter. Predicts every
// result from its own copy of the per-cell counters and previous bits,
// drives cell observations under random gaps and result back-pressure, and
// walks the confirm threshold through its extremes between phases.
// ----------------------------------------------------------------------------
module tb_grid_cell_persistence_filter;
  import gcpf_pkg::*;

  localparam int unsigned GRID_SIDE    = GRID_SIDE_DEFAULT;
  localparam int unsigned CELL_COUNT   = GRID_SIDE * GRID_SIDE;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned POOL_SIZE    = 4;
  localparam int unsigned REPORT_LIMIT = 10;

  // One predicted or observed result transaction.
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   newly_confirmed;
    logic   confirmed;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Cell persistence tracker: mirrors the per-cell state and queues the
  // verdict that each accepted observation must produce.
  // --------------------------------------------------------------------------
  class persistence_tracker;
    cnt_t        threshold;
    cnt_t        hit_count [CELL_COUNT];
    logic        last_seen [CELL_COUNT];
    verdict_t    due_verdicts[$];
    int unsigned mismatches;

    function new();
      threshold  = THRESH_RESET;
      mismatches = 0;
      foreach (hit_count[i]) begin
        hit_count[i] = '0;
        last_seen[i] = 1'b0;
      end
    endfunction

    function void set_threshold(cnt_t value);
      threshold = value;
    endfunction

    function void observe_cell(coord_t row, coord_t col, logic occ);
      verdict_t    v;
      int unsigned addr;
      cnt_t        cnt;
      v.row             = row;
      v.col             = col;
      v.newly_confirmed = 1'b0;
      v.confirmed       = 1'b0;
      // Off-grid cells leave the state alone and report neither flag.
      if (row < GRID_SIDE && col < GRID_SIDE) begin
        addr = row * GRID_SIDE + col;
        cnt  = hit_count[addr];
        // The previous bit, not the arriving one, drives the update.
        if (last_seen[addr]) begin
          if (cnt < threshold) begin
            cnt = cnt + 1'b1;
          end else if (cnt == threshold) begin
            v.newly_confirmed = 1'b1;
            if (cnt != CNT_MAX) cnt = cnt + 1'b1;
          end
        end else if (cnt < threshold) begin
          cnt = '0;
        end
        hit_count[addr] = cnt;
        last_seen[addr] = occ;
        v.confirmed     = (cnt > threshold);
      end
      due_verdicts = {due_verdicts, v};
    endfunction

    function void match_result(verdict_t got);
      verdict_t want;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: row %0d col %0d new %0b conf %0b",
                   got.row, got.col, got.newly_confirmed, got.confirmed);
        return;
      end
      want = due_verdicts.pop_front();
      if (got.row !== want.row || got.col !== want.col ||
          got.newly_confirmed !== want.newly_confirmed ||
          got.confirmed !== want.confirmed) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: exp %0d/%0d new %0b conf %0b, got %0d/%0d new %0b conf %0b",
                   want.row, want.col, want.newly_confirmed, want.confirmed,
                   got.row, got.col, got.newly_confirmed, got.confirmed);
      end
    endfunction

    function int unsigned outstanding();
      return due_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and channels
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gcpf_cell_if   cell_ch ();
  gcpf_result_if res_ch ();
  gcpf_cfg_if    cfg_ch ();

  grid_cell_persistence_filter #(
    .GridSide (GRID_SIDE)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cell_i (cell_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  persistence_tracker tracker;

  // Cleared for stretches of back-to-back traffic on both channels.
  bit          idle_enable = 1'b1;
  int unsigned sink_hold   = 0;

  // Pick an idle length: mostly none, some short, a few long.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (!idle_enable) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: check each accepted transaction against the oldest
  // prediction, then decide whether to stall the next cycles. Sampling at the
  // edge sees the values that stood before it, so the check is free of races.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
      tracker.match_result('{row: res_ch.out_row, col: res_ch.out_col,
                             newly_confirmed: res_ch.newly_confirmed,
                             confirmed: res_ch.confirmed});
    if (sink_hold != 0) begin
      sink_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      sink_hold = idle_cycles();
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one observation, hold it until accepted, then note it and idle.
  // With no idle the valid stays high for the next transaction.
  task automatic send_cell(coord_t row, coord_t col, logic occ);
    int unsigned gap;
    cell_ch.valid    <= 1'b1;
    cell_ch.cell_row <= row;
    cell_ch.cell_col <= col;
    cell_ch.occupied <= occ;
    do @(posedge clk); while (cell_ch.ready !== 1'b1);
    tracker.observe_cell(row, col, occ);
    gap = idle_cycles();
    if (gap != 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop the observation valid and hold off until every result is back.
  // One result per observation, so an empty queue means the block is idle.
  task automatic wait_results_drained();
    cell_ch.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(cnt_t value);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.confirm_threshold <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    tracker.set_threshold(value);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    cnt_t        phase_thr [PHASES-1];
    coord_t      pool_row [POOL_SIZE];
    coord_t      pool_col [POOL_SIZE];
    cnt_t        thr;
    coord_t      row;
    coord_t      col;
    logic        occ;
    int unsigned roll;
    int unsigned slot;

    tracker = new();
    phase_thr = '{cnt_t'(14), CNT_MAX, cnt_t'(1), cnt_t'(0), THRESH_RESET};

    // Hold every input at a known value from time zero.
    rst_n                    = 1'b0;
    cell_ch.valid            = 1'b0;
    cell_ch.cell_row         = '0;
    cell_ch.cell_col         = '0;
    cell_ch.occupied         = 1'b0;
    res_ch.ready             = 1'b0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.confirm_threshold = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: grid corners at the reset threshold. The block sits in its
    // clearing sweep first; the driver simply waits for ready.
    send_cell(7'd0,   7'd0,   1'b1);
    send_cell(7'd127, 7'd127, 1'b0);
    send_cell(7'd0,   7'd127, 1'b1);
    send_cell(7'd127, 7'd0,   1'b0);

    // Lowest nonzero threshold: climb, confirm, then hold above it.
    wait_results_drained();
    write_threshold(cnt_t'(1));
    repeat (4) send_cell(7'd5, 7'd9, 1'b1);

    // Threshold of zero: a set previous bit on a zero counter confirms at once;
    // a clear previous bit on a zero counter is not below it and holds.
    wait_results_drained();
    write_threshold(cnt_t'(0));
    send_cell(7'd0,   7'd0,   1'b1);
    send_cell(7'd127, 7'd127, 1'b1);
    send_cell(7'd127, 7'd127, 1'b1);

    // Threshold of fifteen: count up to the top, confirm and saturate there.
    wait_results_drained();
    write_threshold(CNT_MAX);
    repeat (14) send_cell(7'd5, 7'd9, 1'b1);

    // Random: a small pool of cells seen mostly occupied so counters reach
    // the threshold, with repeats back to back to stress the read-modify-
    // write, broken by empty frames and stray cells across the grid. The pool
    // carries over phases so high counts meet the new threshold.
    foreach (pool_row[i]) begin
      pool_row[i] = coord_t'($urandom);
      pool_col[i] = coord_t'($urandom);
    end
    row = pool_row[0];
    col = pool_col[0];

    for (int p = 0; p < PHASES; p++) begin
      thr = (p < PHASES - 1) ? phase_thr[p] : cnt_t'($urandom_range(1, 14));
      wait_results_drained();
      write_threshold(thr);
      slot = $urandom_range(0, POOL_SIZE - 1);
      pool_row[slot] = coord_t'($urandom);
      pool_col[slot] = coord_t'($urandom);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) idle_enable = ($urandom_range(0, 3) != 0);
        // Now and then hold off until the pipeline is empty.
        if ($urandom_range(0, 59) == 0) wait_results_drained();
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          occ = ($urandom_range(0, 99) < 90);
        end else if (roll < 85) begin
          slot = $urandom_range(0, POOL_SIZE - 1);
          row  = pool_row[slot];
          col  = pool_col[slot];
          occ  = ($urandom_range(0, 99) < 90);
        end else begin
          row = coord_t'($urandom);
          col = coord_t'($urandom);
          occ = 1'($urandom_range(0, 1));
        end
        send_cell(row, col, occ);
      end
    end

    wait_results_drained();
    idle_enable = 1'b1;
    repeat (8) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: the clearing sweep plus every transaction at its longest idle
  // and stall comes to roughly 1.2 ms; allow several times that.
  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
